// File: hdl/binary_to_decimal_ascii_emitter_assert.svh
// assertion macros for the decimal ascii emitter
`ifndef BINARY_TO_DECIMAL_ASCII_EMITTER_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_EMITTER_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define B2DA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/b2da_pkg.sv
// shared types and constants of the decimal ascii emitter
`default_nettype none

package b2da_pkg;

    localparam int VALUE_W            = 32;
    localparam int CHAR_W             = 8;
    localparam int DIGIT_W            = 4;
    localparam int DEFAULT_MAX_DIGITS = 10;
    localparam int DIGIT_BUF_SIZE     = 20;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

    // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every 32-bit v
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;
    localparam int                 PROD_W      = 2 * VALUE_W;
    localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;     // take a new value
        logic step;     // peel off one digit
        logic pop;      // send the newest stored digit
        logic emit_nl;  // send the closing newline
    } cmd_t;

    typedef struct packed {
        logic quot_zero;    // nothing left after this digit
        logic count_full;   // this digit reaches the digit limit
        logic count_empty;  // no stored digits remain
        logic out_free;     // output register can take a character
    } status_t;

endpackage

`default_nettype wire

// File: hdl/b2da_ctrl.sv
// controller state machine of the decimal ascii emitter
`default_nettype none

module b2da_ctrl
    import b2da_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (status.quot_zero || status.count_full)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free && status.count_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CONVERT:
            begin
                cmd.step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.pop     = status.out_free && !status.count_empty;
                cmd.emit_nl = status.out_free && status.count_empty;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/b2da_datapath.sv
// divide-by-ten datapath, digit stack and output register
`default_nettype none

module b2da_datapath
    import b2da_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [CHAR_W-1:0]  char_code,
    output logic                    last
);

    localparam int DIG_LIMIT = (MAX_DIGITS < DIGIT_BUF_SIZE) ? MAX_DIGITS : DIGIT_BUF_SIZE;
    localparam int CNT_W     = $clog2(DIG_LIMIT + 1);
    localparam int IDX_W     = (DIG_LIMIT > 1) ? $clog2(DIG_LIMIT) : 1;

    logic [VALUE_W-1:0] val_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [DIGIT_W-1:0] digit_reg [DIG_LIMIT];
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [VALUE_W-1:0] mul_a;
    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] quot_x10;
    logic [DIGIT_W-1:0] digit;
    logic [CNT_W-1:0]   count_dec;
    logic [DIGIT_W-1:0] top_digit;

    // quotient for the value held now sits in quot_reg; the multiplier
    // works on it for the following digit
    assign mul_a    = cmd.load ? value : VALUE_W'(quot_reg);
    assign prod     = PROD_W'(mul_a) * PROD_W'(RECIP_TEN);
    assign quot_x10 = (VALUE_W'(quot_reg) << 3) + (VALUE_W'(quot_reg) << 1);
    // remainder is below ten, so the low nibble is enough
    assign digit    = val_reg[DIGIT_W-1:0] - quot_x10[DIGIT_W-1:0];

    assign count_dec = count_reg - CNT_W'(1);
    assign top_digit = digit_reg[count_dec[IDX_W-1:0]];

    assign status.quot_zero   = (quot_reg == '0);
    assign status.count_full  = (count_reg == CNT_W'(DIG_LIMIT - 1));
    assign status.count_empty = (count_reg == '0);
    assign status.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load || cmd.step)
        begin
            val_reg  <= cmd.load ? value : VALUE_W'(quot_reg);
            quot_reg <= prod[PROD_W-1:RECIP_SHIFT];
        end
        if (cmd.step)
        begin
            digit_reg[count_reg[IDX_W-1:0]] <= digit;
        end
        if (cmd.pop)
        begin
            char_reg <= CHAR_ZERO + CHAR_W'(top_digit);
            last_reg <= 1'b0;
        end
        else if (cmd.emit_nl)
        begin
            char_reg <= CHAR_NEWLINE;
            last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg <= '0;
            end
            else if (cmd.step)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.pop)
            begin
                count_reg <= count_dec;
            end

            if (cmd.pop || cmd.emit_nl)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// File: hdl/binary_to_decimal_ascii_emitter.sv
// top level of the binary to decimal ascii emitter
//
// input channel: in_valid / in_ready with a 32-bit unsigned value; a
// transaction takes place when both are high at a rising clock edge
// output channel: out_valid / out_ready with char_code and last; the value
// leaves as its decimal digits, most significant first, no leading zeros,
// then a newline (0x0a) flagged by last; zero leaves as "0" and newline
// conversion: the value is split one digit per cycle by a reciprocal
// multiply by ten; once every digit is stored, the first digit enters the
// output register as soon as it is free, then one character per cycle
// while the receiver takes them
// values are handled one at a time, set by the single divide-by-ten step
// and the one-character output register
// the next value is taken as soon as the newline is in the output register
// a stalled receiver holds the current character; the digit stack simply
// waits, nothing is dropped
// reset clears the controller, the digit count and the output valid flag;
// the block comes out of reset idle and ready for a value
`default_nettype none

`include "binary_to_decimal_ascii_emitter_assert.svh"

module binary_to_decimal_ascii_emitter
    import b2da_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [CHAR_W-1:0]  char_code,
    output logic                    last
);

    // command and status between the state machine and the datapath
    cmd_t    cmd;
    status_t status;

    // input transaction and legal output character, for the checks below
    logic    in_txn;
    logic    char_ok;

    b2da_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    b2da_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last      (last)
    );

    assign in_txn  = in_valid && in_ready;

    // every character shown is a digit, or the newline carrying last
    assign char_ok = (last && char_code == CHAR_NEWLINE)
                  || (!last && char_code >= CHAR_ZERO && char_code <= (CHAR_ZERO + 8'd9));

    // at most one datapath command per cycle
    `B2DA_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "b2da: more than one datapath command")

    `B2DA_ASSERT_ALWAYS(a_char_legal, !out_valid || char_ok, "b2da: illegal character on output")

    // after taking a value the block is busy converting it
    `B2DA_ASSERT_NEXT(a_busy_after_accept, in_txn, !in_ready && cmd.step, "b2da: idle after input")

endmodule

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for the binary to decimal ascii emitter
`timescale 1ns / 1ps

module tb
    import b2da_pkg::*;
();

    localparam int DIGIT_LIMIT    = DEFAULT_MAX_DIGITS;
    localparam int NUM_DIRECTED   = 22;
    localparam int RANDOM_ITEMS   = 108;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 60;
    localparam int TIMEOUT_NS     = 5_000_000;

    // one character on the output channel
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } out_char_t;

    // directed row: value, whether the text is typed in, and the digits as
    // ascii right-justified in ten bytes
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [79:0]        text;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [VALUE_W-1:0] value;
    logic               out_valid;
    logic               out_ready;
    logic [CHAR_W-1:0]  char_code;
    logic               last;

    out_char_t     pending_chars[$];
    out_char_t     head_char;
    directed_row_t directed_rows[NUM_DIRECTED];
    int            error_count  = 0;
    int            chars_seen   = 0;
    bit            long_hold_done = 1'b0;

    binary_to_decimal_ascii_emitter #(
        .MAX_DIGITS (DIGIT_LIMIT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // decimal digits of v, most significant first, then the closing newline;
    // zero falls out of the loop as the single digit zero
    function automatic void predict_decimal(input logic [VALUE_W-1:0] v);
        logic [DIGIT_W-1:0] digit_stack [DIGIT_BUF_SIZE];
        logic [VALUE_W-1:0] rest;
        int                 depth;
        int                 limit;
        out_char_t          c;
        limit = (DIGIT_LIMIT < DIGIT_BUF_SIZE) ? DIGIT_LIMIT : DIGIT_BUF_SIZE;
        rest  = v;
        depth = 0;
        do
        begin
            digit_stack[depth] = DIGIT_W'(rest % 10);
            depth++;
            rest = rest / 10;
        end
        while (rest != 0 && depth < limit);
        while (depth > 0)
        begin
            depth--;
            c.code = CHAR_ZERO + CHAR_W'(digit_stack[depth]);
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        c.code = CHAR_NEWLINE;
        c.last = 1'b1;
        pending_chars.push_back(c);
    endfunction

    // idle length between transactions: mostly none or short, a few long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // random value spread over every digit count, with edges of each decade
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned sel;
        int          ndig;
        logic [63:0] lo;
        logic [63:0] hi;
        sel  = $urandom_range(0, 9);
        ndig = $urandom_range(1, 10);
        lo   = 64'd1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
        case (sel)
            0: return $urandom();
            1: return lo[31:0] - VALUE_W'($urandom_range(0, 1));
            2: return hi[31:0] - VALUE_W'($urandom_range(0, 1));
            default: return $urandom_range(hi[31:0], lo[31:0]);
        endcase
    endfunction

    // offer one value and hold it until the transaction; expectations are
    // queued at the accepting edge
    task automatic send_value(input logic [VALUE_W-1:0] v, input logic typed,
                              input logic [79:0] text);
        int        gap;
        int        k;
        out_char_t c;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (typed)
        begin
            // typed text: skip the empty leading bytes, then every digit
            for (k = 9; k >= 0; k--)
            begin
                if (text[k*8 +: 8] != 8'h00)
                begin
                    c.code = text[k*8 +: 8];
                    c.last = 1'b0;
                    pending_chars.push_back(c);
                end
            end
            c.code = CHAR_NEWLINE;
            c.last = 1'b1;
            pending_chars.push_back(c);
        end
        else
            predict_decimal(v);
    endtask

    // stimulus and end of run
    initial
    begin
        int i;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        value    <= '0;
        directed_rows = '{
            '{32'd0,          1'b1, 80'("0")},
            '{32'hFFFF_FFFF,  1'b1, 80'("4294967295")},
            '{32'd1,          1'b1, 80'("1")},
            '{32'd9,          1'b0, 80'h0},
            '{32'd10,         1'b0, 80'h0},
            '{32'd99,         1'b0, 80'h0},
            '{32'd100,        1'b0, 80'h0},
            '{32'd0,          1'b1, 80'("0")},
            '{32'd12345,      1'b0, 80'h0},
            '{32'd999999,     1'b0, 80'h0},
            '{32'd1000000,    1'b0, 80'h0},
            '{32'd999999999,  1'b0, 80'h0},
            '{32'd1000000000, 1'b0, 80'h0},
            '{32'hFFFF_FFFE,  1'b0, 80'h0},
            '{32'h8000_0000,  1'b0, 80'h0},
            '{32'h7FFF_FFFF,  1'b0, 80'h0},
            '{32'hAAAA_AAAA,  1'b0, 80'h0},
            '{32'h5555_5555,  1'b0, 80'h0},
            '{32'd4000000000, 1'b0, 80'h0},
            '{32'd1000000001, 1'b0, 80'h0},
            '{32'd7,          1'b0, 80'h0},
            '{32'hFFFF_FFFF,  1'b1, 80'("4294967295")}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: zero, one, decade edges, full-width values
        for (i = 0; i < NUM_DIRECTED; i++)
            send_value(directed_rows[i].value, directed_rows[i].typed,
                       directed_rows[i].text);

        // random values checked against the predictor
        repeat (RANDOM_ITEMS) send_value(pick_value(), 1'b0, 80'h0);
        in_valid <= 1'b0;

        // drain every expected character, then watch for stray output
        while (pending_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver: random stalls, with one long hold-off so the digit stack
    // and then the input side back up while the sender keeps offering
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && chars_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            // occasional long stretch with the receiver always ready
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12))
                @(posedge clk);
        end
    end

    // output checker: each character transaction against the oldest
    // expectation, field by field
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            chars_seen++;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character: char_code %h last %b", char_code, last);
                error_count++;
            end
            else
            begin
                head_char = pending_chars.pop_front();
                if (char_code !== head_char.code)
                begin
                    $error("char_code mismatch: expected %h actual %h",
                           head_char.code, char_code);
                    error_count++;
                end
                if (last !== head_char.last)
                begin
                    $error("last mismatch: expected %b actual %b",
                           head_char.last, last);
                    error_count++;
                end
            end
        end
    end

    // watchdog against a hung handshake
    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/b2da_pkg.sv
hdl/b2da_ctrl.sv
hdl/b2da_datapath.sv
hdl/binary_to_decimal_ascii_emitter.sv
tb/tb.sv
